// ----- design/icg_pkg.sv -----
package icg_pkg;

    localparam int MAX_MAPS_DEF   = 10;
    localparam int MAX_WIDTH_DEF  = 512;
    localparam int MAX_HEIGHT_DEF = 512;
    localparam int FRAC_BITS_DEF  = 20;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] COUNT_LIMIT = 8'd254;

    localparam logic [9:0] RST_WIDTH  = 10'd512;
    localparam logic [9:0] RST_HEIGHT = 10'd512;
    localparam logic       RST_COLOR  = 1'b0;
    localparam logic [3:0] RST_MAPS   = 4'd5;

    localparam logic [2:0] SEL_THR_LO = 3'd6;
    localparam logic [2:0] SEL_THR_HI = 3'd7;

    localparam logic [2:0] STEP_SEL [6] = '{3'd0, 3'd1, 3'd4, 3'd2, 3'd3, 3'd5};

    localparam logic [1:0] CH_LOW  = 2'd0;
    localparam logic [1:0] CH_MID  = 2'd1;
    localparam logic [1:0] CH_HIGH = 2'd2;

    localparam logic [1:0] PICK_CUR  = 2'd0;
    localparam logic [1:0] PICK_PREV = 2'd1;

    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_COLOR  = 2'd2,
        CFG_MAPS   = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_WARM = 2'd1,
        CMD_PLOT = 2'd2,
        CMD_READ = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_CRD,
        ST_CMUL,
        ST_CACC,
        ST_PROJX,
        ST_PROJY,
        ST_CHK,
        ST_PRD,
        ST_PWR,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [3:0]         coef_map;
        logic [2:0]         coef_sel;
        logic signed [31:0] coef_value;
        logic [30:0]        rnd;
        logic [1:0]         history_pick;
        logic [8:0]         read_x;
        logic [8:0]         read_y;
        logic [1:0]         read_channel;
    } t_in;

    typedef struct packed {
        logic       done_res;
        logic       in_bounds;
        logic [8:0] pixel_x;
        logic [8:0] pixel_y;
        logic [1:0] channel;
        logic [7:0] count_value;
    } t_out;

    typedef struct packed {
        logic [9:0] width;
        logic [9:0] height;
        logic       color;
        logic [3:0] maps;
    } t_cfg;

    typedef struct packed {
        t_cmd kind;
        t_in  item;
    } t_qent;

    typedef struct packed {
        logic clearing;
        logic stopped;
    } t_stat;

endpackage

// ----- design/icg_front.sv -----
module icg_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  icg_pkg::t_in   i_req,
    input  logic           i_pop,
    output icg_pkg::t_qent o_head,
    output logic           o_valid,
    output logic           o_full
);
    import icg_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_qent          r_mem [QUEUE_DEPTH];
    logic [PW-1:0]  r_head;
    logic [PW-1:0]  r_tail;
    logic [CW-1:0]  r_count;
    t_qent          n_ent;

    always_comb begin
        n_ent.kind = t_cmd'(i_req.cmd);
        n_ent.item = i_req;
    end

    assign o_head  = r_mem[r_head];
    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CW'(QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= n_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_tail <= (r_tail == PW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;
            end
            if (i_pop) begin
                r_head <= (r_head == PW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- design/icg_back.sv -----
module icg_back #(
    parameter int MAX_MAPS   = icg_pkg::MAX_MAPS_DEF,
    parameter int MAX_WIDTH  = icg_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = icg_pkg::MAX_HEIGHT_DEF,
    parameter int FRAC_BITS  = icg_pkg::FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  icg_pkg::t_cfg  i_cfg,
    input  icg_pkg::t_qent i_head,
    input  logic           i_qvalid,
    output logic           o_pop,
    output icg_pkg::t_stat o_stat,
    output logic           o_strobe,
    output icg_pkg::t_out  o_res
);
    import icg_pkg::*;

    localparam int MB     = (MAX_MAPS > 1) ? $clog2(MAX_MAPS) : 1;
    localparam int CDEPTH = MAX_MAPS * 6;
    localparam int CAW    = $clog2(CDEPTH);
    localparam int MAXWH  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int SB     = $clog2(MAXWH + 1);
    localparam int PW     = 33 + SB;
    localparam int AXW    = $clog2(MAX_WIDTH);
    localparam int AYW    = $clog2(MAX_HEIGHT);
    localparam int PDEPTH = MAX_WIDTH * MAX_HEIGHT * 3;
    localparam int AW     = $clog2(PDEPTH);
    localparam logic signed [PW-1:0] HALF = PW'(64'd1 << (FRAC_BITS - 1));
    localparam logic signed [PW-1:0] RMASK = PW'((64'd1 << FRAC_BITS) - 1);

    t_state r_state, n_state;

    logic signed [31:0] r_cmem [CDEPTH];
    logic [CDEPTH-1:0]  r_cvalid;
    logic signed [31:0] r_cdata;
    logic               r_cval;
    logic [7:0]         r_pmem [PDEPTH];
    logic [7:0]         r_pdata;
    logic signed [31:0] r_thr [MAX_MAPS][2];

    t_in                r_item;
    t_cmd               r_kind;
    logic [3:0]         r_rem;
    logic [4:0]         r_bit;
    logic [MB-1:0]      r_j;
    logic [2:0]         r_k;
    logic signed [63:0] r_prod;
    logic signed [64:0] r_acc;
    logic signed [31:0] r_pos_x, r_pos_y, r_nx;
    logic signed [PW-1:0] r_tx, r_ty;
    logic [MB-1:0]      r_last, r_last2;
    logic               r_stopped;
    logic               r_hit;
    logic [AXW-1:0]     r_ax;
    logic [AYW-1:0]     r_ay;
    logic [1:0]         r_ch;
    logic [8:0]         r_ox, r_oy;
    logic [AW-1:0]      r_paddr;
    logic [AW-1:0]      r_clr;
    logic               r_strobe;
    t_out               r_res;

    logic               cv_rd, pv_rd, pv_wr, clr_wr, last_clr;
    logic [4:0]         n_maps;
    logic [4:0]         mod_t;
    logic [3:0]         mod_r;
    logic [CAW-1:0]     c_raddr, c_waddr;
    logic signed [31:0] c_eff, c_opnd, aff_res;
    logic signed [65:0] aff_sum;
    logic [SB-1:0]      w_c, h_c, xm, ym, mm;
    logic signed [PW-1:0] mm_s, qx, qy, px, py;
    logic               hit;
    logic [MB-1:0]      pick_i;
    logic signed [31:0] rnd_s;
    logic [1:0]         chan;
    logic [AW-1:0]      p_addr;
    logic [7:0]         p_inc;
    logic               load_ok;

    always_comb begin
        if (i_cfg.maps == 4'd0) begin
            n_maps = 5'd1;
        end else if (32'(i_cfg.maps) > MAX_MAPS) begin
            n_maps = 5'(MAX_MAPS);
        end else begin
            n_maps = {1'b0, i_cfg.maps};
        end
        if (i_cfg.width == 10'd0) begin
            w_c = SB'(1);
        end else if (32'(i_cfg.width) > MAX_WIDTH) begin
            w_c = SB'(MAX_WIDTH);
        end else begin
            w_c = SB'(i_cfg.width);
        end
        if (i_cfg.height == 10'd0) begin
            h_c = SB'(1);
        end else if (32'(i_cfg.height) > MAX_HEIGHT) begin
            h_c = SB'(MAX_HEIGHT);
        end else begin
            h_c = SB'(i_cfg.height);
        end
        xm   = w_c >> 1;
        ym   = h_c >> 1;
        mm   = (xm > ym) ? xm : ym;
        mm_s = {{(PW - SB){1'b0}}, mm};
    end

    always_comb begin
        mod_t = {r_rem, r_item.rnd[r_bit]};
        if (mod_t >= n_maps) begin
            mod_t = mod_t - n_maps;
        end
        mod_r = mod_t[3:0];
    end

    always_comb begin
        c_raddr = CAW'(32'(r_j) * 6 + 32'(STEP_SEL[r_k]));
        c_waddr = CAW'(32'(r_item.coef_map) * 6 + 32'(r_item.coef_sel));
        load_ok = (32'(r_item.coef_map) < MAX_MAPS);
        c_eff   = r_cval ? r_cdata : 32'sd0;
        c_opnd  = (r_k == 3'd0 || r_k == 3'd3) ? r_pos_x : r_pos_y;
        aff_sum = 66'(r_acc >>> FRAC_BITS) + 66'(c_eff);
        if (aff_sum > 66'sd2147483647) begin
            aff_res = 32'sh7fffffff;
        end else if (aff_sum < -66'sd2147483648) begin
            aff_res = 32'sh80000000;
        end else begin
            aff_res = aff_sum[31:0];
        end
    end

    always_comb begin
        qx  = r_tx[PW-1] ? ((r_tx + RMASK) >>> FRAC_BITS) : (r_tx >>> FRAC_BITS);
        qy  = r_ty[PW-1] ? ((r_ty + RMASK) >>> FRAC_BITS) : (r_ty >>> FRAC_BITS);
        px  = {{(PW - SB){1'b0}}, xm} + qx;
        py  = {{(PW - SB){1'b0}}, ym} + qy;
        hit = !px[PW-1] && !py[PW-1]
              && (px < {{(PW - SB){1'b0}}, w_c}) && (py < {{(PW - SB){1'b0}}, h_c});
        if (r_item.history_pick == PICK_CUR) begin
            pick_i = r_j;
        end else if (r_item.history_pick == PICK_PREV) begin
            pick_i = r_last;
        end else begin
            pick_i = r_last2;
        end
        rnd_s = {1'b0, r_item.rnd};
        if (!i_cfg.color) begin
            chan = CH_LOW;
        end else if (rnd_s < r_thr[pick_i][0]) begin
            chan = CH_LOW;
        end else if (rnd_s < r_thr[pick_i][1]) begin
            chan = CH_MID;
        end else begin
            chan = CH_HIGH;
        end
        p_addr = AW'((AW'(r_ay) * AW'(MAX_WIDTH) + AW'(r_ax)) * AW'(3) + AW'(r_ch));
        p_inc  = r_pdata + 8'd1;
    end

    assign last_clr = (r_clr == AW'(PDEPTH - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (last_clr) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_qvalid) begin
                    case (i_head.kind)
                        CMD_LOAD: n_state = ST_OUT;
                        CMD_WARM: n_state = ST_MOD;
                        CMD_PLOT: n_state = r_stopped ? ST_OUT : ST_MOD;
                        CMD_READ: n_state = ST_PRD;
                        default:  n_state = ST_OUT;
                    endcase
                end
            end
            ST_MOD: begin
                if (r_bit == 5'd0) n_state = ST_CRD;
            end
            ST_CRD: n_state = ST_CMUL;
            ST_CMUL: begin
                if (r_k == 3'd2) begin
                    n_state = ST_CRD;
                end else if (r_k == 3'd5) begin
                    n_state = (r_kind == CMD_PLOT) ? ST_PROJX : ST_OUT;
                end else begin
                    n_state = ST_CACC;
                end
            end
            ST_CACC:  n_state = ST_CRD;
            ST_PROJX: n_state = ST_PROJY;
            ST_PROJY: n_state = ST_CHK;
            ST_CHK:   n_state = hit ? ST_PRD : ST_OUT;
            ST_PRD:   n_state = ST_PWR;
            ST_PWR:   n_state = ST_IDLE;
            ST_OUT:   n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop  = (r_state == ST_IDLE) && i_qvalid;
        cv_rd  = (r_state == ST_CRD);
        pv_rd  = (r_state == ST_PRD) && r_hit;
        pv_wr  = (r_state == ST_PWR) && (r_kind == CMD_PLOT) && (r_pdata < COUNT_LIMIT);
        clr_wr = (r_state == ST_CLEAR);
        o_stat.clearing = (r_state == ST_CLEAR);
        o_stat.stopped  = r_stopped;
        o_strobe = r_strobe;
        o_res    = r_res;
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_OUT) && (r_kind == CMD_LOAD) && load_ok
            && (r_item.coef_sel < SEL_THR_LO)) begin
            r_cmem[c_waddr] <= r_item.coef_value;
        end
        if (cv_rd) begin
            r_cdata <= r_cmem[c_raddr];
            r_cval  <= r_cvalid[c_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (clr_wr) begin
            r_pmem[r_clr] <= 8'd0;
        end else if (pv_wr) begin
            r_pmem[r_paddr] <= p_inc;
        end
        if (pv_rd) begin
            r_pdata <= r_pmem[p_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_item <= i_head.item;
                r_kind <= i_head.kind;
                r_rem  <= 4'd0;
                r_bit  <= 5'd30;
                r_k    <= 3'd0;
                r_ox   <= i_head.item.read_x;
                r_oy   <= i_head.item.read_y;
                r_ax   <= AXW'(i_head.item.read_x);
                r_ay   <= AYW'(i_head.item.read_y);
                r_ch   <= i_head.item.read_channel;
                r_hit  <= (32'(i_head.item.read_x) < MAX_WIDTH)
                          && (32'(i_head.item.read_y) < MAX_HEIGHT)
                          && (i_head.item.read_channel != 2'd3);
            end
            ST_MOD: begin
                r_rem <= mod_r;
                r_bit <= r_bit - 5'd1;
                if (r_bit == 5'd0) begin
                    r_j <= mod_r[MB-1:0];
                end
            end
            ST_CMUL: begin
                r_prod <= c_eff * c_opnd;
                if (r_k == 3'd2) begin
                    r_nx <= aff_res;
                    r_k  <= 3'd3;
                end
            end
            ST_CACC: begin
                if (r_k == 3'd0 || r_k == 3'd3) begin
                    r_acc <= 65'(r_prod);
                end else begin
                    r_acc <= r_acc + 65'(r_prod);
                end
                r_k <= r_k + 3'd1;
            end
            ST_PROJX: r_tx <= PW'(r_pos_x) * mm_s + HALF;
            ST_PROJY: r_ty <= PW'(r_pos_y) * mm_s + HALF;
            ST_CHK: begin
                r_ax  <= AXW'(px);
                r_ay  <= AYW'(py);
                r_ox  <= 9'(px);
                r_oy  <= 9'(py);
                r_ch  <= chan;
                r_hit <= hit;
            end
            ST_PRD:  r_paddr <= p_addr;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_cvalid  <= '0;
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_last    <= '0;
            r_last2   <= '0;
            r_stopped <= 1'b0;
            r_strobe  <= 1'b0;
            r_res     <= '0;
            for (int m = 0; m < MAX_MAPS; m++) begin
                r_thr[m][0] <= '0;
                r_thr[m][1] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_strobe <= 1'b0;
            if (clr_wr) begin
                r_clr <= r_clr + 1'b1;
            end
            if ((r_state == ST_CMUL) && (r_k == 3'd5)) begin
                r_pos_x <= r_nx;
                r_pos_y <= aff_res;
            end
            if (r_state == ST_CHK) begin
                r_last2 <= r_last;
                r_last  <= r_j;
            end
            if (r_state == ST_OUT) begin
                if ((r_kind == CMD_LOAD) && load_ok) begin
                    if (r_item.coef_sel < SEL_THR_LO) begin
                        r_cvalid[c_waddr] <= 1'b1;
                    end else begin
                        r_thr[r_item.coef_map[MB-1:0]][r_item.coef_sel == SEL_THR_HI]
                            <= r_item.coef_value;
                    end
                end
                r_strobe <= 1'b1;
                r_res    <= t_out'({r_stopped, 29'd0});
            end
            if (r_state == ST_PWR) begin
                r_strobe      <= 1'b1;
                r_res.pixel_x <= r_ox;
                r_res.pixel_y <= r_oy;
                r_res.channel <= r_ch;
                if (r_kind == CMD_PLOT) begin
                    r_res.in_bounds <= 1'b1;
                    if (r_pdata < COUNT_LIMIT) begin
                        r_res.count_value <= p_inc;
                        r_res.done_res    <= r_stopped;
                    end else begin
                        r_stopped         <= 1'b1;
                        r_res.count_value <= r_pdata;
                        r_res.done_res    <= 1'b1;
                    end
                end else begin
                    r_res.in_bounds   <= 1'b0;
                    r_res.done_res    <= r_stopped;
                    r_res.count_value <= r_hit ? r_pdata : 8'd0;
                end
            end
        end
    end

endmodule

// ----- design/ifs_chaos_game_density_plotter.sv -----
// channel   direction  handshake                    payload
// request   in         start, busy                  i_req (t_in)
// result    out        o_res_strobe (one cycle)     o_res (t_out)
// config    in         i_cfg_valid, o_cfg_ready     i_cfg_index, i_cfg_data
//
// A warm or plot step runs a restoring remainder for the map choice, then six
// coefficient reads through one memory port and one shared 32x32 multiplier; a plot
// then projects, checks bounds and updates the canvas on a hit. A stopped plot skips
// all of it. After reset the canvas is swept to zero, one entry a cycle; busy stays
// high meanwhile. A two-entry queue takes requests while the sequencer works; busy
// rises when it is full. The receiver cannot stall results.
module ifs_chaos_game_density_plotter #(
    parameter int MAX_MAPS   = icg_pkg::MAX_MAPS_DEF,
    parameter int MAX_WIDTH  = icg_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = icg_pkg::MAX_HEIGHT_DEF,
    parameter int FRAC_BITS  = icg_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  icg_pkg::t_in  i_req,
    output logic          o_res_strobe,
    output icg_pkg::t_out o_res,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [9:0]    i_cfg_data
);
    import icg_pkg::*;

    t_cfg  r_cfg;
    t_qent head;
    t_stat stat;
    logic  q_valid, q_full, q_pop, push;

    assign o_cfg_ready = 1'b1;
    assign busy        = q_full || stat.clearing;
    assign push        = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= RST_WIDTH;
            r_cfg.height <= RST_HEIGHT;
            r_cfg.color  <= RST_COLOR;
            r_cfg.maps   <= RST_MAPS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_WIDTH:  r_cfg.width  <= i_cfg_data;
                CFG_HEIGHT: r_cfg.height <= i_cfg_data;
                CFG_COLOR:  r_cfg.color  <= i_cfg_data[0];
                CFG_MAPS:   r_cfg.maps   <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    icg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (i_req),
        .i_pop   (q_pop),
        .o_head  (head),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    icg_back #(
        .MAX_MAPS   (MAX_MAPS),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_head   (head),
        .i_qvalid (q_valid),
        .o_pop    (q_pop),
        .o_stat   (stat),
        .o_strobe (o_res_strobe),
        .o_res    (o_res)
    );

    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.clearing |-> !o_res_strobe) else $error("result during canvas clear");

    a_stop_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.stopped |=> stat.stopped) else $error("stop flag dropped");

    a_hit_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && o_res.in_bounds) |-> (o_res.count_value != 8'd0))
        else $error("plot hit with zero count");

    a_done_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> (o_res.done_res == stat.stopped))
        else $error("done flag disagrees with stop state");

endmodule

// ----- dv/ifs_chaos_game_density_plotter_tb.sv -----
`timescale 1ns / 1ps

module ifs_chaos_game_density_plotter_tb;
    import icg_pkg::*;

    localparam int CANVAS_DEPTH = MAX_WIDTH_DEF * MAX_HEIGHT_DEF * 3;
    localparam int WATCHDOG_LIMIT = 4_000_000;
    localparam int DRAIN_CYCLES = 80;
    localparam logic [2:0] SEL_A11 = 3'd0;
    localparam logic [2:0] SEL_A12 = 3'd1;
    localparam logic [2:0] SEL_A21 = 3'd2;
    localparam logic [2:0] SEL_A22 = 3'd3;
    localparam logic [2:0] SEL_B1  = 3'd4;
    localparam logic [2:0] SEL_B2  = 3'd5;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_in        i_req;
    logic       o_res_strobe;
    t_out       o_res;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic [9:0] i_cfg_data;

    ifs_chaos_game_density_plotter dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_req(i_req),
        .o_res_strobe(o_res_strobe),
        .o_res(o_res),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // plotter state as predicted
    logic [9:0]         cfg_width;
    logic [9:0]         cfg_height;
    logic               cfg_color;
    logic [3:0]         cfg_maps;
    logic signed [31:0] coefs [MAX_MAPS_DEF*6];
    logic signed [31:0] thresholds [MAX_MAPS_DEF*2];
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [3:0]         hist_last;
    logic [3:0]         hist_second;
    logic               plot_stopped;
    logic [7:0]         density [CANVAS_DEPTH];

    t_out expected_results [$];
    int   mismatches;
    int   idle_cycles;
    int   burst_left;
    bit   pace_on;
    logic [8:0] last_hit_x;
    logic [8:0] last_hit_y;
    logic [1:0] last_hit_ch;

    function automatic logic signed [31:0] affine_term(logic signed [31:0] a,
            logic signed [31:0] u, logic signed [31:0] b, logic signed [31:0] v,
            logic signed [31:0] off);
        longint p1;
        longint p2;
        logic signed [65:0] s;
        p1 = longint'(a) * longint'(u);
        p2 = longint'(b) * longint'(v);
        s = p1;
        s = s + p2;
        s = (s >>> FRAC_BITS_DEF) + off;
        if (s > 66'sh7FFFFFFF) return 32'sh7FFFFFFF;
        if (s < -66'sh80000000) return 32'sh80000000;
        return s[31:0];
    endfunction

    function automatic logic [3:0] advance_point(logic [30:0] rnd);
        int n;
        int j;
        logic signed [31:0] ox;
        n = (cfg_maps < 1) ? 1 : ((cfg_maps > MAX_MAPS_DEF) ? MAX_MAPS_DEF : cfg_maps);
        j = rnd % n;
        ox = point_x;
        point_x = affine_term(coefs[j*6], ox, coefs[j*6+1], point_y, coefs[j*6+4]);
        point_y = affine_term(coefs[j*6+2], ox, coefs[j*6+3], point_y, coefs[j*6+5]);
        return 4'(j);
    endfunction

    function automatic longint project_axis(logic signed [31:0] v, longint mid,
            longint maxmid);
        longint t;
        t = longint'(v) * maxmid + (longint'(1) <<< (FRAC_BITS_DEF - 1));
        return mid + t / (longint'(1) <<< FRAC_BITS_DEF);
    endfunction

    function automatic t_out predict_plot(t_in r);
        t_out res;
        logic [3:0] j;
        logic [3:0] p1;
        logic [3:0] p2;
        logic [3:0] mi;
        longint w;
        longint h;
        longint xm;
        longint ym;
        longint mm;
        longint xs;
        longint ys;
        int idx;
        logic [1:0] c;
        res = '0;
        case (r.cmd)
            CMD_LOAD: begin
                if (r.coef_map < MAX_MAPS_DEF) begin
                    if (r.coef_sel < SEL_THR_LO) coefs[r.coef_map*6 + r.coef_sel] = r.coef_value;
                    else thresholds[r.coef_map*2 + (r.coef_sel - SEL_THR_LO)] = r.coef_value;
                end
            end
            CMD_WARM: begin
                j = advance_point(r.rnd);
            end
            CMD_PLOT: begin
                if (!plot_stopped) begin
                    p1 = hist_last;
                    p2 = hist_second;
                    j = advance_point(r.rnd);
                    w = (cfg_width < 1) ? 1 :
                        ((cfg_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : cfg_width);
                    h = (cfg_height < 1) ? 1 :
                        ((cfg_height > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : cfg_height);
                    xm = w / 2;
                    ym = h / 2;
                    mm = (xm > ym) ? xm : ym;
                    xs = project_axis(point_x, xm, mm);
                    ys = project_axis(point_y, ym, mm);
                    hist_second = p1;
                    hist_last = j;
                    if (xs >= 0 && ys >= 0 && xs < w && ys < h) begin
                        c = CH_LOW;
                        if (cfg_color) begin
                            mi = (r.history_pick == PICK_CUR) ? j :
                                 ((r.history_pick == PICK_PREV) ? p1 : p2);
                            if (mi >= MAX_MAPS_DEF) mi = 0;
                            if ($signed({1'b0, r.rnd}) < thresholds[mi*2]) c = CH_LOW;
                            else if ($signed({1'b0, r.rnd}) < thresholds[mi*2+1]) c = CH_MID;
                            else c = CH_HIGH;
                        end
                        idx = (int'(ys) * MAX_WIDTH_DEF + int'(xs)) * 3 + c;
                        if (density[idx] < COUNT_LIMIT) density[idx] = density[idx] + 8'd1;
                        else plot_stopped = 1'b1;
                        res.in_bounds = 1'b1;
                        res.pixel_x = 9'(xs);
                        res.pixel_y = 9'(ys);
                        res.channel = c;
                        res.count_value = density[idx];
                    end
                end
            end
            default: begin
                res.pixel_x = r.read_x;
                res.pixel_y = r.read_y;
                res.channel = r.read_channel;
                if (r.read_channel < 3)
                    res.count_value =
                        density[(r.read_y*MAX_WIDTH_DEF + r.read_x)*3 + r.read_channel];
            end
        endcase
        res.done_res = plot_stopped;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (start && !busy) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("ifs_chaos_game_density_plotter_tb failed");
            $finish;
        end
        if (o_res_strobe) begin
            if (expected_results.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10) $display("unexpected result %h", o_res);
            end else if (o_res !== expected_results[0]) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display({"mismatch exp done=%0d inb=%0d x=%0d y=%0d ch=%0d cnt=%0d,",
                        " act done=%0d inb=%0d x=%0d y=%0d ch=%0d cnt=%0d"},
                        expected_results[0].done_res, expected_results[0].in_bounds,
                        expected_results[0].pixel_x, expected_results[0].pixel_y,
                        expected_results[0].channel, expected_results[0].count_value,
                        o_res.done_res, o_res.in_bounds, o_res.pixel_x, o_res.pixel_y,
                        o_res.channel, o_res.count_value);
                void'(expected_results.pop_front());
            end else begin
                void'(expected_results.pop_front());
            end
        end
    end

    task automatic send_request(t_in r);
        t_out res;
        int gap;
        if (pace_on && burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 5);
            if (gap > 0) begin
                @(negedge i_clk);
                start = 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        if (burst_left > 0) burst_left = burst_left - 1;
        @(negedge i_clk);
        start = 1'b1;
        i_req = r;
        do @(posedge i_clk); while (busy);
        res = predict_plot(r);
        expected_results.push_back(res);
        if (res.in_bounds) begin
            last_hit_x = res.pixel_x;
            last_hit_y = res.pixel_y;
            last_hit_ch = res.channel;
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        start = 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [9:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_WIDTH:  cfg_width = data;
            CFG_HEIGHT: cfg_height = data;
            CFG_COLOR:  cfg_color = data[0];
            default:    cfg_maps = data[3:0];
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic configure(logic [9:0] w, logic [9:0] h, logic color, logic [3:0] maps);
        wait_idle();
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_COLOR, {9'd0, color});
        write_reg(CFG_MAPS, {6'd0, maps});
    endtask

    function automatic t_in load_req(logic [3:0] m, logic [2:0] sel, logic [31:0] v);
        t_in r;
        r = t_in'({$urandom, $urandom, $urandom});
        r.cmd = CMD_LOAD;
        r.coef_map = m;
        r.coef_sel = sel;
        r.coef_value = v;
        return r;
    endfunction

    function automatic t_in step_req(t_cmd cmd, logic [30:0] rnd, logic [1:0] pick);
        t_in r;
        r = t_in'({$urandom, $urandom, $urandom});
        r.cmd = cmd;
        r.rnd = rnd;
        r.history_pick = pick;
        return r;
    endfunction

    function automatic t_in read_req(logic [8:0] x, logic [8:0] y, logic [1:0] ch);
        t_in r;
        r = t_in'({$urandom, $urandom, $urandom});
        r.cmd = CMD_READ;
        r.read_x = x;
        r.read_y = y;
        r.read_channel = ch;
        return r;
    endfunction

    function automatic logic [31:0] contract_coef();
        return 32'($signed($urandom_range(0, 943718)) - 471859);
    endfunction

    task automatic load_map(logic [3:0] m);
        logic [31:0] lo;
        lo = $urandom;
        send_request(load_req(m, SEL_A11, contract_coef()));
        send_request(load_req(m, SEL_A12, contract_coef()));
        send_request(load_req(m, SEL_A21, contract_coef()));
        send_request(load_req(m, SEL_A22, contract_coef()));
        send_request(load_req(m, SEL_B1, 32'($signed($urandom_range(0, 1048576)) - 524288)));
        send_request(load_req(m, SEL_B2, 32'($signed($urandom_range(0, 1048576)) - 524288)));
        send_request(load_req(m, SEL_THR_LO, {1'b0, lo[30:0] >> 1}));
        send_request(load_req(m, SEL_THR_HI, {1'b0, lo[30:0]}));
    endtask

    task automatic test_reset_reads();
        send_request(read_req(9'd0, 9'd0, 2'd0));
        send_request(read_req(9'd511, 9'd511, 2'd2));
        send_request(read_req(9'd511, 9'd0, 2'd3));
    endtask

    task automatic test_loads_and_gray_plot();
        send_request(load_req(4'd0, SEL_A11, 32'sh00080000));
        send_request(load_req(4'd0, SEL_A22, 32'sh00080000));
        send_request(load_req(4'd0, SEL_B1, 32'sh00040000));
        send_request(load_req(4'd15, SEL_A11, 32'hFFFFFFFF));
        send_request(load_req(4'd9, SEL_THR_HI, 32'h7FFFFFFF));
        send_request(step_req(CMD_WARM, 31'd0, PICK_CUR));
        send_request(step_req(CMD_PLOT, 31'd0, PICK_CUR));
        send_request(step_req(CMD_PLOT, 31'h7FFFFFFF, PICK_CUR));
        send_request(read_req(last_hit_x, last_hit_y, 2'd0));
    endtask

    task automatic test_saturation();
        send_request(load_req(4'd1, SEL_A11, 32'h7FFFFFFF));
        send_request(load_req(4'd1, SEL_B1, 32'h7FFFFFFF));
        send_request(load_req(4'd1, SEL_A22, 32'h80000000));
        send_request(load_req(4'd1, SEL_B2, 32'h80000000));
        configure(10'd512, 10'd512, 1'b0, 4'd0);
        send_request(step_req(CMD_WARM, 31'd1, PICK_CUR));
        configure(10'd512, 10'd512, 1'b0, 4'd15);
        send_request(step_req(CMD_PLOT, 31'd1, PICK_CUR));
        send_request(step_req(CMD_PLOT, 31'd11, PICK_CUR));
    endtask

    task automatic test_color_history();
        int k;
        for (k = 0; k < 10; k++) load_map(4'(k));
        configure(10'd1023, 10'd0, 1'b1, 4'd10);
        for (k = 0; k < 4; k++) send_request(step_req(CMD_PLOT, 31'($urandom), 2'(k)));
        configure(10'd0, 10'd1023, 1'b1, 4'd1);
        send_request(step_req(CMD_PLOT, 31'($urandom), 2'd3));
        send_request(read_req(last_hit_x, last_hit_y, last_hit_ch));
    endtask

    task automatic test_random_rendering();
        int phase;
        int k;
        int sel;
        for (phase = 0; phase < 10; phase++) begin
            configure(10'($urandom_range(8, 512)), 10'($urandom_range(8, 512)),
                1'($urandom), 4'($urandom_range(1, 10)));
            pace_on = (phase % 4) != 3;
            for (k = 0; k < 3; k++) load_map(4'($urandom_range(0, 9)));
            for (k = 0; k < 55; k++) begin
                sel = $urandom_range(0, 99);
                if (sel < 4)
                    send_request(load_req(4'($urandom), 3'($urandom), $urandom));
                else if (sel < 10)
                    send_request(load_req(4'($urandom_range(0, 9)), 3'($urandom_range(0, 5)),
                        contract_coef()));
                else if (sel < 22)
                    send_request(step_req(CMD_WARM, 31'($urandom), 2'($urandom)));
                else if (sel < 78)
                    send_request(step_req(CMD_PLOT, 31'($urandom), 2'($urandom)));
                else if (sel < 90)
                    send_request(read_req(last_hit_x, last_hit_y, last_hit_ch));
                else
                    send_request(read_req(9'($urandom), 9'($urandom), 2'($urandom)));
            end
        end
        pace_on = 1'b1;
    endtask

    task automatic test_stop();
        int k;
        configure(10'd1, 10'd1, 1'b0, 4'd3);
        for (k = 0; k < 256; k++) send_request(step_req(CMD_PLOT, 31'($urandom), 2'($urandom)));
        send_request(step_req(CMD_WARM, 31'($urandom), PICK_CUR));
        send_request(step_req(CMD_PLOT, 31'($urandom), PICK_CUR));
        send_request(read_req(9'd0, 9'd0, 2'd0));
    endtask

    initial begin
        int k;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_WIDTH;
        i_cfg_data = '0;
        mismatches = 0;
        idle_cycles = 0;
        burst_left = 0;
        pace_on = 1'b1;
        last_hit_x = '0;
        last_hit_y = '0;
        last_hit_ch = '0;
        cfg_width = RST_WIDTH;
        cfg_height = RST_HEIGHT;
        cfg_color = RST_COLOR;
        cfg_maps = RST_MAPS;
        for (k = 0; k < MAX_MAPS_DEF*6; k++) coefs[k] = '0;
        for (k = 0; k < MAX_MAPS_DEF*2; k++) thresholds[k] = '0;
        for (k = 0; k < CANVAS_DEPTH; k++) density[k] = '0;
        point_x = '0;
        point_y = '0;
        hist_last = '0;
        hist_second = '0;
        plot_stopped = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_reads();
        test_loads_and_gray_plot();
        test_saturation();
        test_color_history();
        test_random_rendering();
        test_stop();

        wait_idle();
        if (mismatches == 0) begin
            $display("ifs_chaos_game_density_plotter_tb passed");
        end else begin
            $display("ifs_chaos_game_density_plotter_tb failed");
        end
        $finish;
    end

endmodule
